### hw/rtl/lrsp_pkg.sv
`default_nettype none

package lrsp_pkg;

  typedef enum logic [1:0] {
    PH_OP  = 2'd0,
    PH_ID  = 2'd1,
    PH_LEN = 2'd2,
    PH_STR = 2'd3
  } phase_t;

  localparam logic [7:0] OP_BYTE_INSERT     = 8'h01;
  localparam logic [7:0] OP_BYTE_UPDATE     = 8'h02;
  localparam logic [7:0] OP_BYTE_DELETE     = 8'h03;
  localparam logic [7:0] OP_BYTE_COMMIT     = 8'hFF;
  localparam logic [7:0] OP_BYTE_ROLLBACK   = 8'hFE;
  localparam logic [7:0] OP_BYTE_CHECKPOINT = 8'hFD;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_UPDATE     = 3'd1;
  localparam logic [2:0] OP_DELETE     = 3'd2;
  localparam logic [2:0] OP_COMMIT     = 3'd3;
  localparam logic [2:0] OP_ROLLBACK   = 3'd4;
  localparam logic [2:0] OP_CHECKPOINT = 3'd5;

  localparam logic [2:0] ROLE_OP      = 3'd0;
  localparam logic [2:0] ROLE_ID      = 3'd1;
  localparam logic [2:0] ROLE_LEN     = 3'd2;
  localparam logic [2:0] ROLE_TABLE   = 3'd3;
  localparam logic [2:0] ROLE_KEY     = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
  localparam logic [2:0] ROLE_DISCARD = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OP  = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_HALTED  = 2'd3;

  localparam logic [1:0] SLOT_PAYLOAD = 2'd2;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  byte_count;
    logic [31:0] bytes_left;
    logic [63:0] id_accum;
    logic [31:0] len_accum;
    logic [2:0]  held_op;
    logic [1:0]  string_slot;
    logic        halted;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_OP,
    byte_count:  3'd0,
    bytes_left:  32'd0,
    id_accum:    64'd0,
    len_accum:   32'd0,
    held_op:     3'd0,
    string_slot: 2'd0,
    halted:      1'b0
  };

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [2:0]  op_kind;
    logic [63:0] txn_ident;
    logic [31:0] string_length;
    logic        record_done;
    logic [1:0]  parse_status;
    logic        end_echo;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/log_record_stream_parser_core.sv
// Write-ahead-log record parser, one log byte per beat.
// Input channel: in_valid/in_ready with in_log_byte and in_log_end; a beat
// with in_log_end high is the last byte of the log buffer.
// Result channel: out_valid/out_ready; every input beat yields exactly one
// result beat carrying the byte's role, the current op, the transaction id
// and string length assembled so far (op, id and length read zero on a
// discarded byte), a record-done flag, a status code and an echo of the
// end flag. The result of an accepted beat is registered and shown in the
// cycle after it is accepted. Throughput is one byte per cycle while
// out_ready stays high; the parse state register and the result register
// load on the same accept, so this single register stage sets the rate.
// in_ready is high whenever the result register is empty or is being
// drained in the same cycle. When the receiver stalls, the pending result
// holds and in_ready drops until it is taken.
// Reset is synchronous and active low; it empties the result register and
// returns the parser to waiting for an op byte. The parser also returns to
// that state after every beat that carries the end flag.
`default_nettype none

module log_record_stream_parser_core (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [7:0]  in_log_byte,
  input  wire  logic        in_log_end,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [2:0]        out_byte_role,
  output logic [2:0]        out_op_kind,
  output logic [63:0]       out_txn_ident,
  output logic [31:0]       out_string_length,
  output logic              out_record_done,
  output logic [1:0]        out_parse_status,
  output logic              out_end_echo
);

  lrsp_pkg::state_t  state_r;
  lrsp_pkg::state_t  state_nxt;
  lrsp_pkg::result_t res_nxt;
  lrsp_pkg::result_t res_r;
  logic              accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lrsp_state_reg u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .state_nxt (state_nxt),
    .state_r   (state_r)
  );

  lrsp_step u_step (
    .cur      (state_r),
    .log_byte (in_log_byte),
    .log_end  (in_log_end),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  lrsp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_nxt   (res_nxt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_r     (res_r)
  );

  assign out_byte_role     = res_r.byte_role;
  assign out_op_kind       = res_r.op_kind;
  assign out_txn_ident     = res_r.txn_ident;
  assign out_string_length = res_r.string_length;
  assign out_record_done   = res_r.record_done;
  assign out_parse_status  = res_r.parse_status;
  assign out_end_echo      = res_r.end_echo;

endmodule

`default_nettype wire

### hw/rtl/lrsp_step.sv
`default_nettype none

module lrsp_step (
  input  wire  lrsp_pkg::state_t  cur,
  input  wire  logic [7:0]        log_byte,
  input  wire  logic              log_end,
  output lrsp_pkg::state_t        nxt,
  output lrsp_pkg::result_t       res
);

  always_comb begin
    lrsp_pkg::state_t s;
    logic             normal;
    logic             done;
    logic             fin;
    logic [1:0]       k;
    logic [31:0]      len_base;
    logic [31:0]      left_dec;
    logic             op_ok;
    logic [2:0]       op_val;

    s        = cur;
    normal   = 1'b0;
    done     = 1'b0;
    fin      = 1'b0;
    k        = cur.byte_count[1:0];
    len_base = (k == 2'd0) ? 32'd0 : cur.len_accum;
    left_dec = cur.bytes_left - 32'd1;
    op_ok    = 1'b1;
    op_val   = lrsp_pkg::OP_INSERT;

    case (log_byte)
      lrsp_pkg::OP_BYTE_INSERT:     op_val = lrsp_pkg::OP_INSERT;
      lrsp_pkg::OP_BYTE_UPDATE:     op_val = lrsp_pkg::OP_UPDATE;
      lrsp_pkg::OP_BYTE_DELETE:     op_val = lrsp_pkg::OP_DELETE;
      lrsp_pkg::OP_BYTE_COMMIT:     op_val = lrsp_pkg::OP_COMMIT;
      lrsp_pkg::OP_BYTE_ROLLBACK:   op_val = lrsp_pkg::OP_ROLLBACK;
      lrsp_pkg::OP_BYTE_CHECKPOINT: op_val = lrsp_pkg::OP_CHECKPOINT;
      default:                      op_ok  = 1'b0;
    endcase

    res               = '0;
    res.byte_role     = lrsp_pkg::ROLE_DISCARD;
    res.parse_status  = lrsp_pkg::ST_OK;
    res.end_echo      = log_end;

    if (cur.halted) begin
      res.parse_status = lrsp_pkg::ST_HALTED;
    end else begin
      case (cur.phase)
        lrsp_pkg::PH_ID: begin
          s.id_accum = cur.id_accum | ({56'd0, log_byte} << {cur.byte_count, 3'b000});
          if (cur.byte_count == 3'd7) begin
            s.byte_count = 3'd0;
            s.phase      = lrsp_pkg::PH_LEN;
          end else begin
            s.byte_count = cur.byte_count + 3'd1;
          end
          res.byte_role = lrsp_pkg::ROLE_ID;
          normal        = 1'b1;
        end
        lrsp_pkg::PH_LEN: begin
          s.len_accum   = len_base | ({24'd0, log_byte} << {k, 3'b000});
          res.byte_role = lrsp_pkg::ROLE_LEN;
          if (k == 2'd3) begin
            s.byte_count = 3'd0;
            if (s.len_accum == 32'd0) begin
              fin = 1'b1;
            end else begin
              s.bytes_left = s.len_accum;
              s.phase      = lrsp_pkg::PH_STR;
            end
          end else begin
            s.byte_count = {1'b0, k + 2'd1};
          end
          normal = 1'b1;
        end
        lrsp_pkg::PH_STR: begin
          case (cur.string_slot)
            2'd0:    res.byte_role = lrsp_pkg::ROLE_TABLE;
            2'd1:    res.byte_role = lrsp_pkg::ROLE_KEY;
            default: res.byte_role = lrsp_pkg::ROLE_PAYLOAD;
          endcase
          s.bytes_left = left_dec;
          fin          = (left_dec == 32'd0);
          normal       = 1'b1;
        end
        default: begin
          if (!op_ok) begin
            res.parse_status = lrsp_pkg::ST_BAD_OP;
            s.halted         = 1'b1;
          end else begin
            s.held_op     = op_val;
            s.id_accum    = 64'd0;
            s.len_accum   = 32'd0;
            s.byte_count  = 3'd0;
            s.bytes_left  = 32'd0;
            s.string_slot = 2'd0;
            s.phase       = lrsp_pkg::PH_ID;
            res.byte_role = lrsp_pkg::ROLE_OP;
            normal        = 1'b1;
          end
        end
      endcase
    end

    if (fin) begin
      if (cur.string_slot >= lrsp_pkg::SLOT_PAYLOAD) begin
        s.string_slot = 2'd0;
        s.phase       = lrsp_pkg::PH_OP;
        done          = 1'b1;
      end else begin
        s.string_slot = cur.string_slot + 2'd1;
        s.phase       = lrsp_pkg::PH_LEN;
      end
    end

    if (normal) begin
      res.op_kind       = s.held_op;
      res.txn_ident     = s.id_accum;
      res.string_length = s.len_accum;
      if (log_end && !done) begin
        res.parse_status = lrsp_pkg::ST_TRUNC;
      end
    end
    res.record_done = done;

    nxt = log_end ? lrsp_pkg::STATE_RESET : s;
  end

endmodule

`default_nettype wire

### hw/rtl/lrsp_state_reg.sv
`default_nettype none

module lrsp_state_reg (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              load,
  input  wire  lrsp_pkg::state_t  state_nxt,
  output lrsp_pkg::state_t        state_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrsp_pkg::STATE_RESET;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lrsp_out_reg.sv
`default_nettype none

module lrsp_out_reg (
  input  wire  logic               clk,
  input  wire  logic               rst_n,
  input  wire  logic               load,
  input  wire  lrsp_pkg::result_t  res_nxt,
  input  wire  logic               out_ready,
  output logic                     out_valid,
  output lrsp_pkg::result_t        res_r
);

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/lrsp_checker.sv
`default_nettype none

module lrsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_byte_role,
  input wire logic [2:0]  out_op_kind,
  input wire logic [63:0] out_txn_ident,
  input wire logic [31:0] out_string_length,
  input wire logic        out_record_done,
  input wire logic [1:0]  out_parse_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted byte produced no result beat.");

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_done |->
      out_parse_status == lrsp_pkg::ST_OK && out_byte_role != lrsp_pkg::ROLE_DISCARD)
    else $error("Record completed with a bad status or on a discarded byte.");

  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_role == lrsp_pkg::ROLE_DISCARD |->
      out_op_kind == 3'd0 && out_txn_ident == 64'd0 && out_string_length == 32'd0)
    else $error("Discarded byte carries nonzero fields.");

  a_halt_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_parse_status == lrsp_pkg::ST_HALTED ||
                  out_parse_status == lrsp_pkg::ST_BAD_OP) |->
      out_byte_role == lrsp_pkg::ROLE_DISCARD)
    else $error("Halted or bad op byte not tagged as discarded.");

endmodule

bind log_record_stream_parser_core lrsp_checker u_lrsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte_role     (out_byte_role),
  .out_op_kind       (out_op_kind),
  .out_txn_ident     (out_txn_ident),
  .out_string_length (out_string_length),
  .out_record_done   (out_record_done),
  .out_parse_status  (out_parse_status)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_ITEMS = 1950;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } log_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_log_byte;
  logic        in_log_end;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_byte_role;
  logic [2:0]  out_op_kind;
  logic [63:0] out_txn_ident;
  logic [31:0] out_string_length;
  logic        out_record_done;
  logic [1:0]  out_parse_status;
  logic        out_end_echo;

  log_beat_t           log_beats[$];
  lrsp_pkg::result_t   parse_results_due[$];

  lrsp_pkg::phase_t mdl_phase;
  logic [2:0]  mdl_count;
  logic [31:0] mdl_left;
  logic [63:0] mdl_ident;
  logic [31:0] mdl_length;
  logic [2:0]  mdl_op;
  logic [1:0]  mdl_slot;
  logic        mdl_halted;

  int unsigned cycle_count = 0;
  int unsigned beats_in = 0;
  int unsigned beats_offered = 0;
  int unsigned results_seen = 0;
  int unsigned records_seen = 0;
  int unsigned bad_ops_seen = 0;
  int unsigned truncations_seen = 0;
  int unsigned logs_built = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 0;

  log_record_stream_parser_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_log_byte       (in_log_byte),
    .in_log_end        (in_log_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_role     (out_byte_role),
    .out_op_kind       (out_op_kind),
    .out_txn_ident     (out_txn_ident),
    .out_string_length (out_string_length),
    .out_record_done   (out_record_done),
    .out_parse_status  (out_parse_status),
    .out_end_echo      (out_end_echo)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void clear_parser();
    mdl_phase  = lrsp_pkg::PH_OP;
    mdl_count  = 3'd0;
    mdl_left   = 32'd0;
    mdl_ident  = 64'd0;
    mdl_length = 32'd0;
    mdl_op     = 3'd0;
    mdl_slot   = 2'd0;
    mdl_halted = 1'b0;
  endfunction

  function automatic bit close_string();
    if (mdl_slot >= lrsp_pkg::SLOT_PAYLOAD) begin
      mdl_slot  = 2'd0;
      mdl_phase = lrsp_pkg::PH_OP;
      return 1'b1;
    end
    mdl_slot  = mdl_slot + 2'd1;
    mdl_phase = lrsp_pkg::PH_LEN;
    return 1'b0;
  endfunction

  function automatic lrsp_pkg::result_t parse_log_byte(logic [7:0] data, logic is_last);
    lrsp_pkg::result_t res;
    bit                normal;
    logic [1:0]        k;
    res = '0;
    res.byte_role = lrsp_pkg::ROLE_DISCARD;
    res.parse_status = lrsp_pkg::ST_OK;
    normal = 1'b0;
    if (mdl_halted) begin
      res.parse_status = lrsp_pkg::ST_HALTED;
    end else if (mdl_phase == lrsp_pkg::PH_ID) begin
      mdl_ident = mdl_ident | ({56'd0, data} << (8 * mdl_count));
      if (mdl_count == 3'd7) begin
        mdl_count = 3'd0;
        mdl_phase = lrsp_pkg::PH_LEN;
      end else begin
        mdl_count = mdl_count + 3'd1;
      end
      res.byte_role = lrsp_pkg::ROLE_ID;
      normal = 1'b1;
    end else if (mdl_phase == lrsp_pkg::PH_LEN) begin
      k = mdl_count[1:0];
      if (k == 2'd0) begin
        mdl_length = 32'd0;
      end
      mdl_length = mdl_length | ({24'd0, data} << (8 * k));
      res.byte_role = lrsp_pkg::ROLE_LEN;
      if (k == 2'd3) begin
        mdl_count = 3'd0;
        if (mdl_length == 32'd0) begin
          res.record_done = close_string();
        end else begin
          mdl_left  = mdl_length;
          mdl_phase = lrsp_pkg::PH_STR;
        end
      end else begin
        mdl_count = {1'b0, k} + 3'd1;
      end
      normal = 1'b1;
    end else if (mdl_phase == lrsp_pkg::PH_STR) begin
      res.byte_role = lrsp_pkg::ROLE_TABLE + {1'b0, mdl_slot};
      mdl_left = mdl_left - 32'd1;
      if (mdl_left == 32'd0) begin
        res.record_done = close_string();
      end
      normal = 1'b1;
    end else begin
      normal = 1'b1;
      case (data)
        lrsp_pkg::OP_BYTE_INSERT:     mdl_op = lrsp_pkg::OP_INSERT;
        lrsp_pkg::OP_BYTE_UPDATE:     mdl_op = lrsp_pkg::OP_UPDATE;
        lrsp_pkg::OP_BYTE_DELETE:     mdl_op = lrsp_pkg::OP_DELETE;
        lrsp_pkg::OP_BYTE_COMMIT:     mdl_op = lrsp_pkg::OP_COMMIT;
        lrsp_pkg::OP_BYTE_ROLLBACK:   mdl_op = lrsp_pkg::OP_ROLLBACK;
        lrsp_pkg::OP_BYTE_CHECKPOINT: mdl_op = lrsp_pkg::OP_CHECKPOINT;
        default:                      normal = 1'b0;
      endcase
      if (normal) begin
        mdl_ident  = 64'd0;
        mdl_length = 32'd0;
        mdl_count  = 3'd0;
        mdl_left   = 32'd0;
        mdl_slot   = 2'd0;
        mdl_phase  = lrsp_pkg::PH_ID;
        res.byte_role = lrsp_pkg::ROLE_OP;
      end else begin
        res.parse_status = lrsp_pkg::ST_BAD_OP;
        mdl_halted = 1'b1;
      end
    end
    if (normal) begin
      res.op_kind = mdl_op;
      res.txn_ident = mdl_ident;
      res.string_length = mdl_length;
      if (is_last && !res.record_done) begin
        res.parse_status = lrsp_pkg::ST_TRUNC;
      end
    end
    res.end_echo = is_last;
    if (is_last) begin
      clear_parser();
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic bit may_idle();
    return !(cycle_count >= 1200 && cycle_count < 1900);
  endfunction

  task automatic add_beat(logic [7:0] data);
    log_beat_t beat;
    beat.data = data;
    beat.is_last = 1'b0;
    log_beats.insert(log_beats.size(), beat);
  endtask

  task automatic close_log();
    log_beats[$].is_last = 1'b1;
    logs_built++;
  endtask

  function automatic logic [7:0] pick_op_byte();
    case ($urandom_range(5))
      0: return lrsp_pkg::OP_BYTE_INSERT;
      1: return lrsp_pkg::OP_BYTE_UPDATE;
      2: return lrsp_pkg::OP_BYTE_DELETE;
      3: return lrsp_pkg::OP_BYTE_COMMIT;
      4: return lrsp_pkg::OP_BYTE_ROLLBACK;
      default: return lrsp_pkg::OP_BYTE_CHECKPOINT;
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_op_byte();
    logic [7:0] data;
    do begin
      data = 8'($urandom_range(255));
    end while (data inside {lrsp_pkg::OP_BYTE_INSERT, lrsp_pkg::OP_BYTE_UPDATE,
                            lrsp_pkg::OP_BYTE_DELETE, lrsp_pkg::OP_BYTE_COMMIT,
                            lrsp_pkg::OP_BYTE_ROLLBACK, lrsp_pkg::OP_BYTE_CHECKPOINT});
    return data;
  endfunction

  task automatic add_record(logic [7:0] op_byte, logic [63:0] ident, int unsigned max_len);
    int unsigned len;
    add_beat(op_byte);
    for (int i = 0; i < 8; i++) begin
      add_beat(ident[8*i +: 8]);
    end
    for (int s = 0; s < 3; s++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(max_len);
      for (int i = 0; i < 4; i++) begin
        add_beat(len[8*i +: 8]);
      end
      for (int i = 0; i < len; i++) begin
        add_beat(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic build_random_log();
    int unsigned start;
    int unsigned cut;
    int unsigned kind;
    kind = $urandom_range(99);
    start = log_beats.size();
    if (kind < 70) begin
      repeat ($urandom_range(1, 3)) add_record(pick_op_byte(), {$urandom, $urandom}, 6);
      close_log();
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 2)) add_record(pick_op_byte(), {$urandom, $urandom}, 6);
      cut = start + $urandom_range(log_beats.size() - start - 1);
      while (log_beats.size() > cut + 1) begin
        void'(log_beats.pop_back());
      end
      close_log();
    end else if (kind < 88) begin
      if ($urandom_range(1)) begin
        add_record(pick_op_byte(), {$urandom, $urandom}, 4);
      end
      add_beat(pick_bad_op_byte());
      repeat ($urandom_range(4)) add_beat(8'($urandom_range(255)));
      close_log();
    end else if (kind < 95) begin
      add_beat(pick_op_byte());
      repeat (8) add_beat(8'($urandom_range(255)));
      if ($urandom_range(1)) begin
        repeat (4) add_beat(8'd0);
      end
      repeat (3) add_beat(8'($urandom_range(255)));
      add_beat(8'($urandom_range(1, 255)));
      repeat ($urandom_range(8)) add_beat(8'($urandom_range(255)));
      close_log();
    end else begin
      repeat ($urandom_range(1, 6)) add_beat(8'($urandom_range(255)));
      close_log();
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin : result_predict
    lrsp_pkg::result_t due;
    if (rst_n && in_valid && in_ready) begin
      due = parse_log_byte(in_log_byte, in_log_end);
      parse_results_due.insert(parse_results_due.size(), due);
      beats_in++;
    end
  end

  always @(posedge clk) begin : result_check
    lrsp_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_record_done) records_seen++;
      if (out_parse_status == lrsp_pkg::ST_BAD_OP) bad_ops_seen++;
      if (out_parse_status == lrsp_pkg::ST_TRUNC) truncations_seen++;
      if (parse_results_due.size() == 0) begin
        $error("Result beat with no expected result pending");
        mismatches++;
      end else begin
        want = parse_results_due.pop_front();
        check_field("byte_role", want.byte_role, out_byte_role);
        check_field("op_kind", want.op_kind, out_op_kind);
        check_field("txn_ident", want.txn_ident, out_txn_ident);
        check_field("string_length", want.string_length, out_string_length);
        check_field("record_done", want.record_done, out_record_done);
        check_field("parse_status", want.parse_status, out_parse_status);
        check_field("end_echo", want.end_echo, out_end_echo);
      end
    end
  end

  always @(negedge clk) begin : log_driver
    log_beat_t beat;
    if (rst_n) begin
      if (!in_valid || beats_in == beats_offered) begin
        if (log_beats.size() > 0 && !(may_idle() && $urandom_range(99) < 6)) begin
          beat = log_beats.pop_front();
          in_valid <= 1'b1;
          in_log_byte <= beat.data;
          in_log_end <= beat.is_last;
          beats_offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!pressure_done && results_seen >= 600) begin
        pressure_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(may_idle() && $urandom_range(99) < 6);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_log_byte = 8'd0;
    in_log_end = 1'b0;
    out_ready = 1'b0;
    clear_parser();

    add_beat(8'h00);
    add_beat(8'hFF);
    close_log();
    add_beat(lrsp_pkg::OP_BYTE_INSERT);
    close_log();
    add_beat(lrsp_pkg::OP_BYTE_UPDATE);
    close_log();
    add_beat(lrsp_pkg::OP_BYTE_DELETE);
    close_log();
    add_beat(lrsp_pkg::OP_BYTE_ROLLBACK);
    close_log();
    add_beat(lrsp_pkg::OP_BYTE_CHECKPOINT);
    close_log();
    add_record(lrsp_pkg::OP_BYTE_COMMIT, '1, 0);
    close_log();

    while (log_beats.size() < RANDOM_ITEMS + 28) begin
      build_random_log();
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (log_beats.size() > 0 || beats_in != beats_offered || in_valid ||
           parse_results_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (parse_results_due.size() > 0) begin
      $error("%0d expected results never arrived", parse_results_due.size());
      mismatches++;
    end

    $display("Parsed %0d log bytes in %0d logs: %0d records completed, %0d bad op bytes,",
             results_seen, logs_built, records_seen, bad_ops_seen);
    $display("%0d logs ended mid-record, with one long receiver stall.", truncations_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
